// ===== rtl/tbt_pkg.sv =====
// ----------------------------------------------------------------------------
// tbt_pkg
// Shared widths, payload types and sequencer states of the tangent basis block.
// ----------------------------------------------------------------------------
package tbt_pkg;

    localparam int POS_W   = 32;
    localparam int UV_W    = 24;
    localparam int OUT_W   = 32;
    localparam int THR_W   = 32;
    localparam int FRAC_W  = 16;
    // operand width of the shared multiplier: holds any position or uv delta
    localparam int MUL_W   = ((POS_W > UV_W) ? POS_W : UV_W) + 1;
    localparam int PROD_W  = 2 * MUL_W;
    // numerators and the determinant are differences of two products
    localparam int NUM_W   = PROD_W + 1;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(43);

    typedef struct packed {
        logic signed [POS_W-1:0] corner_x;
        logic signed [POS_W-1:0] corner_y;
        logic signed [POS_W-1:0] corner_z;
        logic signed [UV_W-1:0]  corner_u;
        logic signed [UV_W-1:0]  corner_v;
    } t_corner;

    typedef struct packed {
        logic signed [OUT_W-1:0] tangent_x;
        logic signed [OUT_W-1:0] tangent_y;
        logic signed [OUT_W-1:0] tangent_z;
        logic signed [OUT_W-1:0] bitangent_x;
        logic signed [OUT_W-1:0] bitangent_y;
        logic signed [OUT_W-1:0] bitangent_z;
        logic                    degenerate;
        logic                    clipped;
    } t_result;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DET_A,
        S_DET_B,
        S_DET_C,
        S_DET_CHK,
        S_NUM_A,
        S_NUM_B,
        S_NUM_C,
        S_DIV,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_ROUND
    } t_div_state;

endpackage

// ===== rtl/triangle_tangent_basis.sv =====
// ----------------------------------------------------------------------------
// triangle_tangent_basis
// Per-triangle tangent and bitangent from corner positions and uvs.
// ----------------------------------------------------------------------------
// Corners arrive one request at a time on the input channel (i_in_valid,
// o_in_stall). The first two corners of a triangle are stored and give no
// result. The third corner starts a sequencer that drives one shared
// multiplier and one bit-serial divider: the determinant steps (S_DET_A to
// S_DET_CHK), then for each of six components the multiply steps (S_NUM_A
// to S_NUM_C) and a division. A degenerate triangle skips the divisions and
// goes straight from the determinant check to the result.
// The result waits in an output register (o_out_valid, i_out_stall) until the
// receiver takes it; o_in_stall stays high while work or a held result is
// pending. zero_threshold is written through i_cfg_valid/o_cfg_ready, always
// ready. Reset is synchronous, active low: it returns the corner count to the
// first corner, drops all valid flags and sets zero_threshold to 43.
// ----------------------------------------------------------------------------
module triangle_tangent_basis (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  tbt_pkg::t_corner           i_corner,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output tbt_pkg::t_result           o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [tbt_pkg::THR_W-1:0]  i_cfg_data
);
    import tbt_pkg::*;

    t_state                  r_state, n_state;
    logic [1:0]              r_phase;
    logic [THR_W-1:0]        r_thr;
    logic signed [MUL_W-1:0] r_p0 [3];
    logic signed [MUL_W-1:0] r_p1 [3];
    logic signed [MUL_W-1:0] r_t0 [2];
    logic signed [MUL_W-1:0] r_t1 [2];
    logic signed [MUL_W-1:0] r_dp1 [3];
    logic signed [MUL_W-1:0] r_dp2 [3];
    logic signed [MUL_W-1:0] r_du1, r_dv1, r_du2, r_dv2;
    logic signed [PROD_W-1:0] r_acc;
    logic signed [NUM_W-1:0]  r_det;
    logic [1:0]              r_k;
    logic                    r_sel;
    t_result                 r_result;

    logic                    w_in_acc;
    logic signed [MUL_W-1:0] w_pos [3];
    logic signed [MUL_W-1:0] w_tex [2];
    logic signed [MUL_W-1:0] w_ma, w_mb;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [NUM_W-1:0] w_diff;
    logic [NUM_W-1:0]        w_det_abs;
    logic                    w_degen;
    logic                    w_div_start;
    logic                    w_div_done;
    logic signed [OUT_W-1:0] w_div_q;
    logic                    w_div_clip;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // sign-extended corner fields
    assign w_pos[0] = MUL_W'(i_corner.corner_x);
    assign w_pos[1] = MUL_W'(i_corner.corner_y);
    assign w_pos[2] = MUL_W'(i_corner.corner_z);
    assign w_tex[0] = MUL_W'(i_corner.corner_u);
    assign w_tex[1] = MUL_W'(i_corner.corner_v);

    // shared multiplier
    tbt_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (w_ma),
        .i_b    (w_mb),
        .o_prod (w_prod)
    );

    // operand select by sequencer step
    always_comb begin
        case (r_state)
            S_DET_A: begin
                w_ma = r_du1;
                w_mb = r_dv2;
            end
            S_DET_B: begin
                w_ma = r_dv1;
                w_mb = r_du2;
            end
            S_NUM_A: begin
                w_ma = r_sel ? r_dp2[r_k] : r_dp1[r_k];
                w_mb = r_sel ? r_du1 : r_dv2;
            end
            S_NUM_B: begin
                w_ma = r_sel ? r_dp1[r_k] : r_dp2[r_k];
                w_mb = r_sel ? r_du2 : r_dv1;
            end
            default: begin
                w_ma = r_du1;
                w_mb = r_dv2;
            end
        endcase
    end

    assign w_diff      = NUM_W'(r_acc) - NUM_W'(w_prod);
    assign w_det_abs   = r_det[NUM_W-1] ? NUM_W'(-r_det) : NUM_W'(r_det);
    assign w_degen     = (w_det_abs <= NUM_W'(r_thr));
    assign w_div_start = (r_state == S_NUM_C);

    // shared divider
    tbt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_diff),
        .i_den   (r_det),
        .o_done  (w_div_done),
        .o_q     (w_div_q),
        .o_clip  (w_div_clip)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= 2'd0;
            r_thr   <= THR_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_thr <= i_cfg_data;
            end
            if (w_in_acc) begin
                r_phase <= (r_phase == 2'd0) ? 2'd1 : (r_phase == 2'd1) ? 2'd2 : 2'd0;
            end
        end
    end

    // corner storage and deltas
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            if (r_phase == 2'd1) begin
                for (int i = 0; i < 3; i++) r_p1[i] <= w_pos[i];
                for (int i = 0; i < 2; i++) r_t1[i] <= w_tex[i];
            end else if (r_phase == 2'd2) begin
                for (int i = 0; i < 3; i++) begin
                    r_dp1[i] <= r_p1[i] - r_p0[i];
                    r_dp2[i] <= w_pos[i] - r_p0[i];
                end
                r_du1 <= r_t1[0] - r_t0[0];
                r_dv1 <= r_t1[1] - r_t0[1];
                r_du2 <= w_tex[0] - r_t0[0];
                r_dv2 <= w_tex[1] - r_t0[1];
            end else begin
                for (int i = 0; i < 3; i++) r_p0[i] <= w_pos[i];
                for (int i = 0; i < 2; i++) r_t0[i] <= w_tex[i];
            end
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_DET_B: r_acc <= w_prod;
            S_DET_C: r_det <= w_diff;
            S_DET_CHK: begin
                r_k   <= 2'd0;
                r_sel <= 1'b0;
                // cleared result, flagged when the determinant counts as zero
                r_result <= t_result'({{(6*OUT_W){1'b0}}, w_degen, 1'b0});
            end
            S_NUM_B: r_acc <= w_prod;
            S_DIV: begin
                if (w_div_done) begin
                    case ({r_sel, r_k})
                        3'b000:  r_result.tangent_x   <= w_div_q;
                        3'b001:  r_result.tangent_y   <= w_div_q;
                        3'b010:  r_result.tangent_z   <= w_div_q;
                        3'b100:  r_result.bitangent_x <= w_div_q;
                        3'b101:  r_result.bitangent_y <= w_div_q;
                        default: r_result.bitangent_z <= w_div_q;
                    endcase
                    if (w_div_clip) r_result.clipped <= 1'b1;
                    if (r_sel) begin
                        r_sel <= 1'b0;
                        r_k   <= r_k + 2'd1;
                    end else begin
                        r_sel <= 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (w_in_acc && r_phase == 2'd2) n_state = S_DET_A;
            S_DET_A:   n_state = S_DET_B;
            S_DET_B:   n_state = S_DET_C;
            S_DET_C:   n_state = S_DET_CHK;
            S_DET_CHK: n_state = w_degen ? S_OUT : S_NUM_A;
            S_NUM_A:   n_state = S_NUM_B;
            S_NUM_B:   n_state = S_NUM_C;
            S_NUM_C:   n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = (r_sel && r_k == 2'd2) ? S_OUT : S_NUM_A;
                end
            end
            S_OUT:     if (!i_out_stall) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    assign o_out_valid = (r_state == S_OUT);
    assign o_result    = r_result;

    // checks
    a_degen_no_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.degenerate |-> !o_result.clipped)
        else $error("degenerate result with clip set");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_result.degenerate |-> o_result.tangent_x == '0 &&
        o_result.bitangent_z == '0)
        else $error("degenerate result not zero");

    a_div_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_DIV)
        else $error("divider finished outside a division step");

    a_result_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> r_phase == 2'd0)
        else $error("result pending with corner count not at first corner");

endmodule

// ===== rtl/tbt_mul.sv =====
// ----------------------------------------------------------------------------
// tbt_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module tbt_mul (
    input  logic                                 i_clk,
    input  logic signed [tbt_pkg::MUL_W-1:0]     i_a,
    input  logic signed [tbt_pkg::MUL_W-1:0]     i_b,
    output logic signed [tbt_pkg::PROD_W-1:0]    o_prod
);
    import tbt_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // one product per cycle
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

// ===== rtl/tbt_div.sv =====
// ----------------------------------------------------------------------------
// tbt_div
// Restoring divider, one quotient bit a cycle: round(num * 2^16 / den),
// ties away from zero, saturated to a 32-bit signed result.
// ----------------------------------------------------------------------------
module tbt_div (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [tbt_pkg::NUM_W-1:0]     i_num,
    input  logic signed [tbt_pkg::NUM_W-1:0]     i_den,
    output logic                                 o_done,
    output logic signed [tbt_pkg::OUT_W-1:0]     o_q,
    output logic                                 o_clip
);
    import tbt_pkg::*;

    localparam int DIV_N = NUM_W + FRAC_W;
    localparam int CNT_W = $clog2(DIV_N + 1);

    t_div_state       r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_neg, n_neg;
    logic [DIV_N-1:0] r_n, n_n;
    logic [DIV_N-1:0] r_quo, n_quo;
    logic [NUM_W-1:0] r_rem, n_rem;
    logic [NUM_W-1:0] r_den, n_den;
    logic             r_done, n_done;
    logic [OUT_W-1:0] r_q, n_q;
    logic             r_clip, n_clip;

    logic [NUM_W:0]   w_trial;
    logic [DIV_N:0]   w_rnd;
    logic [DIV_N:0]   w_lim;
    logic [DIV_N:0]   w_sat;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_n    <= n_n;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_q    <= n_q;
        r_clip <= n_clip;
    end

    // one shift and trial subtract per cycle, then round and saturate
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_n     = r_n;
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_den   = r_den;
        n_done  = 1'b0;
        n_q     = r_q;
        n_clip  = r_clip;
        w_trial = {r_rem, r_n[DIV_N-1]};
        w_rnd   = {1'b0, r_quo};
        w_lim   = r_neg ? (DIV_N+1)'(64'h8000_0000) : (DIV_N+1)'(64'h7FFF_FFFF);
        w_sat   = '0;
        case (r_state)
            D_IDLE: begin
                if (i_start) begin
                    n_neg   = i_num[NUM_W-1] ^ i_den[NUM_W-1];
                    n_n     = {(i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num)),
                               {FRAC_W{1'b0}}};
                    n_den   = i_den[NUM_W-1] ? NUM_W'(-i_den) : NUM_W'(i_den);
                    n_rem   = '0;
                    n_quo   = '0;
                    n_cnt   = CNT_W'(DIV_N);
                    n_state = D_RUN;
                end
            end
            D_RUN: begin
                n_n = {r_n[DIV_N-2:0], 1'b0};
                if (w_trial >= {1'b0, r_den}) begin
                    n_rem = NUM_W'(w_trial - {1'b0, r_den});
                    n_quo = {r_quo[DIV_N-2:0], 1'b1};
                end else begin
                    n_rem = w_trial[NUM_W-1:0];
                    n_quo = {r_quo[DIV_N-2:0], 1'b0};
                end
                n_cnt = r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    n_state = D_ROUND;
                end
            end
            D_ROUND: begin
                if ({r_rem, 1'b0} >= {1'b0, r_den}) begin
                    w_rnd = {1'b0, r_quo} + (DIV_N+1)'(1);
                end
                if (w_rnd > w_lim) begin
                    w_sat  = w_lim;
                    n_clip = 1'b1;
                end else begin
                    w_sat  = w_rnd;
                    n_clip = 1'b0;
                end
                n_q     = r_neg ? OUT_W'(-w_sat) : OUT_W'(w_sat);
                n_done  = 1'b1;
                n_state = D_IDLE;
            end
            default: begin
                n_state = D_IDLE;
            end
        endcase
    end

    assign o_done = r_done;
    assign o_q    = r_q;
    assign o_clip = r_clip;

endmodule
